@@ sv/ttlkv_pkg.sv @@
// Shared types and constants for the key/value table with time-to-live.
// Depends on nothing; ttlkv_ctrl and the top level refer to it by scoped names.
`default_nettype none

package ttlkv_pkg;

    localparam int ENTRIES    = 128;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 64;
    localparam int SEC_W      = 32;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);

    // Operation codes carried in the kind field.
    localparam logic [2:0] KIND_STORE    = 3'd0;
    localparam logic [2:0] KIND_RETRIEVE = 3'd1;
    localparam logic [2:0] KIND_DELETE   = 3'd2;
    localparam logic [2:0] KIND_FLUSH    = 3'd3;
    localparam logic [2:0] KIND_TICK     = 3'd4;

    // Result codes carried in the status field.
    localparam logic [2:0] ST_STORED    = 3'd0;
    localparam logic [2:0] ST_EXISTS    = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_DELETED   = 3'd5;
    localparam logic [2:0] ST_FLUSHED   = 3'd6;
    localparam logic [2:0] ST_TICK_DONE = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] key;
        logic [63:0] value;
        logic [31:0] lifetime;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] read_value;
        logic [7:0]  live_count;
    } out_beat_t;

    // One table entry as held in the entry memory.
    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [SEC_W-1:0]      lifetime;
        logic [SEC_W-1:0]      stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

@@ sv/ttlkv_ram.sv @@
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Generic; no package dependency.
`default_nettype none

module ttlkv_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 192
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ sv/ttlkv_ctrl.sv @@
// Operation sequencer: scans the entry memory once per operation, keeps the valid bits,
// the seconds counter and the live count. Depends on ttlkv_pkg.
`default_nettype none

module ttlkv_ctrl (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire ttlkv_pkg::in_beat_t            in_beat,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output ttlkv_pkg::out_beat_t                res_beat,
    output logic                                ram_we,
    output logic [ttlkv_pkg::IDX_W-1:0]         ram_waddr,
    output ttlkv_pkg::entry_t                   ram_wdata,
    output logic [ttlkv_pkg::IDX_W-1:0]         ram_raddr,
    input  wire ttlkv_pkg::entry_t              ram_rdata
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_COMMIT = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    localparam logic [ttlkv_pkg::IDX_W-1:0] LAST_IDX =
        ttlkv_pkg::IDX_W'(ttlkv_pkg::ENTRIES - 1);

    state_t                                state_reg, state_next;
    logic [ttlkv_pkg::ENTRIES-1:0]         valid_reg, valid_next;
    logic [ttlkv_pkg::SEC_W-1:0]           seconds_reg, seconds_next;
    logic [ttlkv_pkg::IDX_W-1:0]           issue_idx_reg, issue_idx_next;
    logic                                  issue_more_reg, issue_more_next;
    logic                                  chk_valid_reg, chk_valid_next;
    logic [ttlkv_pkg::IDX_W-1:0]           chk_idx_reg, chk_idx_next;
    logic                                  match_found_reg, match_found_next;
    logic [ttlkv_pkg::IDX_W-1:0]           match_idx_reg, match_idx_next;
    logic [ttlkv_pkg::VALUE_BITS-1:0]      match_value_reg, match_value_next;
    logic                                  free_found_reg, free_found_next;
    logic [ttlkv_pkg::IDX_W-1:0]           free_idx_reg, free_idx_next;
    logic [ttlkv_pkg::CNT_W-1:0]           cnt_reg, cnt_next;
    ttlkv_pkg::in_beat_t                   op_reg, op_next;
    ttlkv_pkg::out_beat_t                  res_reg, res_next;

    logic                                  ent_valid;
    logic [ttlkv_pkg::SEC_W-1:0]           elapsed;
    logic                                  ent_lapsed;
    logic                                  ent_live;
    logic                                  key_hit;
    logic [ttlkv_pkg::CNT_W-1:0]           cnt_final;

    // Lapse check and key match on the entry whose read data has just arrived.
    assign ent_valid  = valid_reg[chk_idx_reg];
    assign elapsed    = seconds_reg - ram_rdata.stamp;
    assign ent_lapsed = ent_valid && (ram_rdata.lifetime != '0)
                        && (elapsed > ram_rdata.lifetime);
    assign ent_live   = ent_valid && !ent_lapsed;
    assign key_hit    = ram_rdata.key == op_reg.key[ttlkv_pkg::KEY_BITS-1:0];

    always_comb begin
        state_next       = state_reg;
        valid_next       = valid_reg;
        seconds_next     = seconds_reg;
        issue_idx_next   = issue_idx_reg;
        issue_more_next  = issue_more_reg;
        chk_valid_next   = 1'b0;
        chk_idx_next     = chk_idx_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        match_value_next = match_value_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        cnt_next         = cnt_reg;
        op_next          = op_reg;
        res_next         = res_reg;
        cnt_final        = cnt_reg;
        ram_we           = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next = in_beat;
                    if (in_beat.kind == ttlkv_pkg::KIND_TICK) begin
                        seconds_next = seconds_reg + 1'b1;
                    end
                    issue_idx_next   = '0;
                    issue_more_next  = 1'b1;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    cnt_next         = '0;
                    state_next       = S_SCAN;
                end
            end
            S_SCAN: begin
                if (issue_more_reg) begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = issue_idx_reg;
                    if (issue_idx_reg == LAST_IDX) begin
                        issue_more_next = 1'b0;
                    end else begin
                        issue_idx_next = issue_idx_reg + 1'b1;
                    end
                end
                if (chk_valid_reg) begin
                    if (ent_lapsed) begin
                        valid_next[chk_idx_reg] = 1'b0;
                    end
                    if (ent_live) begin
                        cnt_next = cnt_reg + 1'b1;
                        if (key_hit && !match_found_reg) begin
                            match_found_next = 1'b1;
                            match_idx_next   = chk_idx_reg;
                            match_value_next = ram_rdata.value;
                        end
                    end else if (!free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                    if (chk_idx_reg == LAST_IDX) begin
                        state_next = S_COMMIT;
                    end
                end
            end
            S_COMMIT: begin
                res_next.status     = ttlkv_pkg::ST_NOT_FOUND;
                res_next.read_value = '0;
                case (op_reg.kind)
                    ttlkv_pkg::KIND_STORE: begin
                        if (match_found_reg) begin
                            res_next.status = ttlkv_pkg::ST_EXISTS;
                        end else if (!free_found_reg) begin
                            res_next.status = ttlkv_pkg::ST_FULL;
                        end else begin
                            ram_we                   = 1'b1;
                            valid_next[free_idx_reg] = 1'b1;
                            cnt_final                = cnt_reg + 1'b1;
                            res_next.status          = ttlkv_pkg::ST_STORED;
                        end
                    end
                    ttlkv_pkg::KIND_RETRIEVE: begin
                        if (match_found_reg) begin
                            res_next.status     = ttlkv_pkg::ST_FOUND;
                            res_next.read_value = 64'(match_value_reg);
                        end
                    end
                    ttlkv_pkg::KIND_DELETE: begin
                        if (match_found_reg) begin
                            valid_next[match_idx_reg] = 1'b0;
                            cnt_final                 = cnt_reg - 1'b1;
                            res_next.status           = ttlkv_pkg::ST_DELETED;
                        end
                    end
                    ttlkv_pkg::KIND_FLUSH: begin
                        valid_next      = '0;
                        cnt_final       = '0;
                        res_next.status = ttlkv_pkg::ST_FLUSHED;
                    end
                    ttlkv_pkg::KIND_TICK: begin
                        res_next.status = ttlkv_pkg::ST_TICK_DONE;
                    end
                    default: begin
                        res_next.status = ttlkv_pkg::ST_NOT_FOUND;
                    end
                endcase
                cnt_next            = cnt_final;
                res_next.live_count = (32'(cnt_final) > 32'd255) ? 8'hFF : 8'(cnt_final);
                state_next          = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            seconds_reg    <= '0;
            issue_more_reg <= 1'b0;
            chk_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            seconds_reg    <= seconds_next;
            issue_more_reg <= issue_more_next;
            chk_valid_reg  <= chk_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        issue_idx_reg   <= issue_idx_next;
        chk_idx_reg     <= chk_idx_next;
        match_found_reg <= match_found_next;
        match_idx_reg   <= match_idx_next;
        match_value_reg <= match_value_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        op_reg          <= op_next;
        res_reg         <= res_next;
    end

    assign in_ready  = state_reg == S_IDLE;
    assign res_valid = state_reg == S_DONE;
    assign res_beat  = res_reg;

    assign ram_raddr       = issue_idx_reg;
    assign ram_waddr       = free_idx_reg;
    assign ram_wdata.key   = op_reg.key[ttlkv_pkg::KEY_BITS-1:0];
    assign ram_wdata.value = op_reg.value[ttlkv_pkg::VALUE_BITS-1:0];
    assign ram_wdata.lifetime = op_reg.lifetime;
    assign ram_wdata.stamp = seconds_reg;

    // A store must only ever land in a slot that the scan found free.
    a_store_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !valid_reg[free_idx_reg])
        else $error("store written over a live entry");

    // The running count must agree with the valid bits once the result is ready.
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |-> (32'(cnt_reg) == 32'($countones(valid_reg))))
        else $error("live count disagrees with valid bits");

    // No memory read may still be in flight when a new operation can be taken.
    a_scan_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> (!chk_valid_reg && !issue_more_reg))
        else $error("new operation taken while a scan is active");

    // The seconds counter moves only on an accepted tick.
    a_seconds_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_valid && in_ready && (in_beat.kind == ttlkv_pkg::KIND_TICK))
        |=> $stable(seconds_reg))
        else $error("seconds counter moved without a tick");

endmodule

`default_nettype wire

@@ sv/ttl_key_value_table.sv @@
// Top level of the key/value table with time-to-live: handshakes and result register.
// Depends on ttlkv_pkg, ttlkv_ram and ttlkv_ctrl.
//
//   Channel | Ports                      | Direction | Beat contents
//   --------+----------------------------+-----------+--------------------------------------
//   input   | s_valid, s_ready, s_beat   | in        | kind, key, value, lifetime
//   result  | m_valid, m_ready, m_beat   | out       | status, read_value, live_count
//
// Every operation, including flush and tick, takes one full pass over the entry
// memory: one read is issued per entry per cycle and the read data returns in the next
// cycle. The length of that pass is set by the single read port of the entry memory,
// and no new input beat is taken until the result of the operation has been handed on.
// Reset clears the valid bits, the seconds counter and both handshakes; the entry
// memory itself is not cleared, since an entry is only believed while its valid bit is
// set. While a result beat waits in the output register, the next input beat is
// still taken and its scan runs; the result of that scan waits for the register.
`default_nettype none

module ttl_key_value_table (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire ttlkv_pkg::in_beat_t  s_beat,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output ttlkv_pkg::out_beat_t      m_beat
);

    logic                              ram_we;
    logic [ttlkv_pkg::IDX_W-1:0]       ram_waddr;
    logic [ttlkv_pkg::IDX_W-1:0]       ram_raddr;
    ttlkv_pkg::entry_t                 ram_wdata;
    ttlkv_pkg::entry_t                 ram_rdata;
    logic [ttlkv_pkg::ENTRY_W-1:0]     ram_rdata_raw;

    logic                              res_valid;
    logic                              res_ready;
    ttlkv_pkg::out_beat_t              res_beat;

    logic                              m_valid_reg, m_valid_next;
    ttlkv_pkg::out_beat_t              m_beat_reg, m_beat_next;

    // The entry memory holds key, value, lifetime and stamp side by side.
    ttlkv_ram #(
        .DEPTH (ttlkv_pkg::ENTRIES),
        .WIDTH (ttlkv_pkg::ENTRY_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = ram_rdata_raw;

    ttlkv_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_beat   (s_beat),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_beat  (res_beat),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // The output register may be refilled in the same cycle that its beat is taken.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_beat_next  = m_beat_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_beat_next  = res_beat;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_beat_reg <= m_beat_next;
    end

    assign m_valid = m_valid_reg;
    assign m_beat  = m_beat_reg;

endmodule

`default_nettype wire
